@@ design/ocr_pkg.sv @@
// ocr_pkg: shared types and codes for the optimal replacement cache
// no dependencies; used by ocr_cell and optimal_replacement_cache_core

package ocr_pkg;

	// result codes carried on the outcome port
	typedef enum logic [1:0] {
		OUT_HIT    = 2'd0,
		OUT_FILL   = 2'd1,
		OUT_EVICT  = 2'd2,
		OUT_BYPASS = 2'd3
	} outcome_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	// running flags of the scan record handed from cell to cell
	typedef struct packed {
		logic active;     // record is live in this stage
		logic hit;        // a matching valid entry was seen
		logic free;       // an empty live entry was seen
		logic vic_have;   // a victim candidate is held
		logic vic_nr;     // held victim is a never-reused entry
	} scan_flags_t;

	// entry write broadcast from the controller
	typedef struct packed {
		logic en;
		logic never_reused;
	} wr_ctrl_t;

	localparam int DATA_BITS = 32;
	localparam int CFG_BITS  = 5;

endpackage

@@ design/optimal_replacement_cache_core.sv @@
// optimal_replacement_cache_core: top level of the farthest-next-use cache controller
// depends on ocr_pkg and ocr_cell
//
// Usage:
//   An access beat (access_key, next_use, no_reuse) is taken when access_valid is
//   high and access_stall is low. Every access gives exactly one result beat
//   (hit, outcome, evicted_key), taken when result_valid is high and result_stall
//   is low. The entries sit in a row of CAPACITY cells; a scan record walks the
//   row one cell per cycle, collecting the hit slot, the first free slot and the
//   eviction candidate, then the controller writes back to the chosen cell.
//   An access passes the start register, every cell's stage register, the final
//   record register and the output register; one access is in flight at a time,
//   so a new access is taken only once the controller has returned to idle.
//   The result sits in an output register: a new access is taken while it waits.
//   If the receiver still stalls when the next result is ready, the controller
//   holds that result and accepts nothing until the output register frees.
//   cfg_write_en/cfg_write_data set the active entry count (0 acts as 1, values
//   above CAPACITY act as CAPACITY); write only while idle.
//   Reset empties every entry and sets the active count to CAPACITY.

module optimal_replacement_cache_core #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_write_en,
	input  logic [ocr_pkg::CFG_BITS-1:0]      cfg_write_data,
	// access channel
	input  logic                              access_valid,
	output logic                              access_stall,
	input  logic [ocr_pkg::DATA_BITS-1:0]     access_key,
	input  logic [ocr_pkg::DATA_BITS-1:0]     next_use,
	input  logic                              no_reuse,
	// result channel
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              hit,
	output logic [1:0]                        outcome,
	output logic [ocr_pkg::DATA_BITS-1:0]     evicted_key
);

	localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int KW = (KEY_BITS < ocr_pkg::DATA_BITS) ? KEY_BITS : ocr_pkg::DATA_BITS;

	ocr_pkg::state_t state_q, state_d;

	logic [CW-1:0]                 live_q;
	logic [CAPACITY-1:0]           live_vec;
	logic                          start_q;
	logic [KW-1:0]                 acc_key_q;
	logic [ocr_pkg::DATA_BITS-1:0] acc_nu_q;
	logic                          acc_nr_q;

	// scan chain, index g feeds cell g
	ocr_pkg::scan_flags_t          ch_flags     [CAPACITY+1];
	logic [SW-1:0]                 ch_hit_slot  [CAPACITY+1];
	logic [SW-1:0]                 ch_free_slot [CAPACITY+1];
	logic [SW-1:0]                 ch_vic_slot  [CAPACITY+1];
	logic [ocr_pkg::DATA_BITS-1:0] ch_far       [CAPACITY+1];
	logic [KW-1:0]                 ch_vic_key   [CAPACITY+1];

	// final record captured off the end of the row
	ocr_pkg::scan_flags_t          fin_flags_q;
	logic [SW-1:0]                 fin_hit_slot_q;
	logic [SW-1:0]                 fin_free_slot_q;
	logic [SW-1:0]                 fin_vic_slot_q;
	logic [ocr_pkg::DATA_BITS-1:0] fin_far_q;
	logic [KW-1:0]                 fin_vic_key_q;

	ocr_pkg::wr_ctrl_t             wr;
	logic [SW-1:0]                 wr_slot;
	logic                          accept;
	logic                          out_free;
	logic                          out_load;
	ocr_pkg::outcome_t             res_outcome;
	logic [ocr_pkg::DATA_BITS-1:0] res_evicted;

	logic                          result_valid_q;
	logic                          hit_q;
	ocr_pkg::outcome_t             outcome_q;
	logic [ocr_pkg::DATA_BITS-1:0] evicted_q;

	assign accept   = access_valid && !access_stall;
	assign out_free = !result_valid_q || !result_stall;

	// active entry count, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= CW'(CAPACITY);
		end else if (cfg_write_en) begin
			if (cfg_write_data == '0) begin
				live_q <= CW'(1);
			end else if (32'(cfg_write_data) > 32'(CAPACITY)) begin
				live_q <= CW'(CAPACITY);
			end else begin
				live_q <= CW'(cfg_write_data);
			end
		end
	end

	// access holding registers
	always_ff @(posedge clk) begin
		if (accept) begin
			acc_key_q <= access_key[KW-1:0];
			acc_nu_q  <= no_reuse ? '0 : next_use;
			acc_nr_q  <= no_reuse;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= accept;
		end
	end

	// head of the chain: an empty record, live for one cycle
	always_comb begin
		ch_flags[0]        = '0;
		ch_flags[0].active = start_q;
		ch_hit_slot[0]     = '0;
		ch_free_slot[0]    = '0;
		ch_vic_slot[0]     = '0;
		ch_far[0]          = '0;
		ch_vic_key[0]      = '0;
	end

	// row of entry cells
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		assign live_vec[g] = 32'(live_q) > 32'(g);

		ocr_cell #(
			.IDX (g),
			.SW  (SW),
			.KW  (KW)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.acc_key       (acc_key_q),
			.live          (live_vec[g]),
			.in_flags      (ch_flags[g]),
			.in_hit_slot   (ch_hit_slot[g]),
			.in_free_slot  (ch_free_slot[g]),
			.in_vic_slot   (ch_vic_slot[g]),
			.in_far        (ch_far[g]),
			.in_vic_key    (ch_vic_key[g]),
			.out_flags     (ch_flags[g+1]),
			.out_hit_slot  (ch_hit_slot[g+1]),
			.out_free_slot (ch_free_slot[g+1]),
			.out_vic_slot  (ch_vic_slot[g+1]),
			.out_far       (ch_far[g+1]),
			.out_vic_key   (ch_vic_key[g+1]),
			.wr            (wr),
			.wr_slot       (wr_slot),
			.wr_next_use   (acc_nu_q)
		);
	end

	// capture the record leaving the last cell
	always_ff @(posedge clk) begin
		if (ch_flags[CAPACITY].active) begin
			fin_flags_q     <= ch_flags[CAPACITY];
			fin_hit_slot_q  <= ch_hit_slot[CAPACITY];
			fin_free_slot_q <= ch_free_slot[CAPACITY];
			fin_vic_slot_q  <= ch_vic_slot[CAPACITY];
			fin_far_q       <= ch_far[CAPACITY];
			fin_vic_key_q   <= ch_vic_key[CAPACITY];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ocr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, decision and write-back
	always_comb begin
		state_d         = state_q;
		access_stall    = 1'b1;
		out_load        = 1'b0;
		wr.en           = 1'b0;
		wr.never_reused = acc_nr_q;
		wr_slot         = fin_vic_slot_q;
		res_outcome     = ocr_pkg::OUT_BYPASS;
		res_evicted     = '0;

		// outcome from the finished record
		if (fin_flags_q.hit) begin
			res_outcome = ocr_pkg::OUT_HIT;
			wr_slot     = fin_hit_slot_q;
		end else if (fin_flags_q.free) begin
			res_outcome = ocr_pkg::OUT_FILL;
			wr_slot     = fin_free_slot_q;
		end else if (acc_nr_q || (!fin_flags_q.vic_nr && fin_far_q < acc_nu_q)) begin
			res_outcome = ocr_pkg::OUT_BYPASS;
		end else begin
			res_outcome = ocr_pkg::OUT_EVICT;
			res_evicted = ocr_pkg::DATA_BITS'(fin_vic_key_q);
		end

		case (state_q)
			ocr_pkg::ST_IDLE: begin
				access_stall = 1'b0;
				if (access_valid) begin
					state_d = ocr_pkg::ST_SCAN;
				end
			end
			ocr_pkg::ST_SCAN: begin
				if (ch_flags[CAPACITY].active) begin
					state_d = ocr_pkg::ST_DONE;
				end
			end
			ocr_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					wr.en    = (res_outcome != ocr_pkg::OUT_BYPASS);
					state_d  = ocr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ocr_pkg::ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_load) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_q     <= (res_outcome == ocr_pkg::OUT_HIT);
			outcome_q <= res_outcome;
			evicted_q <= res_evicted;
		end
	end

	assign result_valid = result_valid_q;
	assign hit          = hit_q;
	assign outcome      = outcome_q;
	assign evicted_key  = evicted_q;

endmodule

@@ design/ocr_cell.sv @@
// ocr_cell: one cache entry plus one stage of the scan chain
// depends on ocr_pkg (scan_flags_t, wr_ctrl_t, DATA_BITS)

module ocr_cell #(
	parameter int IDX = 0,
	parameter int SW  = 4,
	parameter int KW  = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// access under test, held by the controller
	input  logic [KW-1:0]             acc_key,
	input  logic                      live,
	// scan record from the left neighbor
	input  ocr_pkg::scan_flags_t      in_flags,
	input  logic [SW-1:0]             in_hit_slot,
	input  logic [SW-1:0]             in_free_slot,
	input  logic [SW-1:0]             in_vic_slot,
	input  logic [ocr_pkg::DATA_BITS-1:0] in_far,
	input  logic [KW-1:0]             in_vic_key,
	// scan record to the right neighbor
	output ocr_pkg::scan_flags_t      out_flags,
	output logic [SW-1:0]             out_hit_slot,
	output logic [SW-1:0]             out_free_slot,
	output logic [SW-1:0]             out_vic_slot,
	output logic [ocr_pkg::DATA_BITS-1:0] out_far,
	output logic [KW-1:0]             out_vic_key,
	// entry write
	input  ocr_pkg::wr_ctrl_t         wr,
	input  logic [SW-1:0]             wr_slot,
	input  logic [ocr_pkg::DATA_BITS-1:0] wr_next_use
);

	localparam logic [SW-1:0] MY_SLOT = SW'(IDX);

	logic                          valid_q;
	logic [KW-1:0]                 key_q;
	logic [ocr_pkg::DATA_BITS-1:0] next_use_q;
	logic                          never_reused_q;

	ocr_pkg::scan_flags_t          flags_d, flags_q;
	logic [SW-1:0]                 hit_slot_d, hit_slot_q;
	logic [SW-1:0]                 free_slot_d, free_slot_q;
	logic [SW-1:0]                 vic_slot_d, vic_slot_q;
	logic [ocr_pkg::DATA_BITS-1:0] far_d, far_q;
	logic [KW-1:0]                 vic_key_d, vic_key_q;

	// entry storage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr.en && wr_slot == MY_SLOT) begin
			valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr_slot == MY_SLOT) begin
			key_q          <= acc_key;
			next_use_q     <= wr_next_use;
			never_reused_q <= wr.never_reused;
		end
	end

	// fold this entry into the passing record
	always_comb begin
		flags_d     = in_flags;
		hit_slot_d  = in_hit_slot;
		free_slot_d = in_free_slot;
		vic_slot_d  = in_vic_slot;
		far_d       = in_far;
		vic_key_d   = in_vic_key;
		if (in_flags.active && live) begin
			// lowest matching slot takes the hit
			if (!in_flags.hit && valid_q && key_q == acc_key) begin
				flags_d.hit = 1'b1;
				hit_slot_d  = MY_SLOT;
			end
			// lowest empty slot takes a fill
			if (!in_flags.free && !valid_q) begin
				flags_d.free = 1'b1;
				free_slot_d  = MY_SLOT;
			end
			// victim: first never-reused entry, else farthest next use
			if (!in_flags.vic_nr) begin
				if (never_reused_q) begin
					flags_d.vic_nr   = 1'b1;
					flags_d.vic_have = 1'b1;
					vic_slot_d       = MY_SLOT;
					vic_key_d        = key_q;
				end else if (!in_flags.vic_have || next_use_q > in_far) begin
					flags_d.vic_have = 1'b1;
					far_d            = next_use_q;
					vic_slot_d       = MY_SLOT;
					vic_key_d        = key_q;
				end
			end
		end
	end

	// stage register toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			flags_q <= flags_d;
		end
	end

	always_ff @(posedge clk) begin
		hit_slot_q  <= hit_slot_d;
		free_slot_q <= free_slot_d;
		vic_slot_q  <= vic_slot_d;
		far_q       <= far_d;
		vic_key_q   <= vic_key_d;
	end

	assign out_flags     = flags_q;
	assign out_hit_slot  = hit_slot_q;
	assign out_free_slot = free_slot_q;
	assign out_vic_slot  = vic_slot_q;
	assign out_far       = far_q;
	assign out_vic_key   = vic_key_q;

endmodule

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for optimal_replacement_cache_core
// depends on ocr_pkg and the core; predicts farthest-next-use replacement in a
// scoreboard class and checks every result beat against it

module tb;

	localparam int CAPACITY      = 16;
	localparam int LATENCY       = CAPACITY + 2;
	localparam int RANDOM_ITEMS  = 1450;
	localparam int IDLE_LIMIT    = 2000;
	localparam int LONG_HOLD     = 300;
	localparam int POOL_MAX      = 24;
	localparam int REPORT_MAX    = 10;
	localparam int DATA_BITS     = ocr_pkg::DATA_BITS;
	localparam int CFG_BITS      = ocr_pkg::CFG_BITS;

	typedef struct packed {
		logic                 hit;
		ocr_pkg::outcome_t    outcome;
		logic [DATA_BITS-1:0] evicted_key;
	} cache_result_t;

	// mirror of the entry store plus the queue of predicted results
	class cache_scoreboard;
		bit                   slot_valid [CAPACITY];
		logic [DATA_BITS-1:0] slot_key   [CAPACITY];
		logic [DATA_BITS-1:0] slot_next  [CAPACITY];
		bit                   slot_nr    [CAPACITY];
		logic [CFG_BITS-1:0]  active_cfg;
		cache_result_t        pending [$];
		int                   mismatches;

		function new();
			for (int s = 0; s < CAPACITY; s++) begin
				slot_valid[s] = 1'b0;
				slot_key[s]   = '0;
				slot_next[s]  = '0;
				slot_nr[s]    = 1'b0;
			end
			active_cfg = CFG_BITS'(CAPACITY);
			mismatches = 0;
		endfunction

		function void set_active(logic [CFG_BITS-1:0] v);
			active_cfg = v;
		endfunction

		function void store_entry(int s, logic [DATA_BITS-1:0] k, logic [DATA_BITS-1:0] nu,
				bit nr);
			slot_valid[s] = 1'b1;
			slot_key[s]   = k;
			slot_next[s]  = nr ? '0 : nu;
			slot_nr[s]    = nr;
		endfunction

		// accepted access beat: work out its result and update the mirror
		function void note_access(logic [DATA_BITS-1:0] k, logic [DATA_BITS-1:0] nu, bit nr);
			cache_result_t        r;
			int                   live;
			int                   victim;
			bit                   victim_nr;
			bit                   have;
			logic [DATA_BITS-1:0] far;
			live = (active_cfg == 0) ? 1 : ((active_cfg > CAPACITY) ? CAPACITY : active_cfg);
			r.hit         = 1'b0;
			r.outcome     = ocr_pkg::OUT_HIT;
			r.evicted_key = '0;
			victim        = 0;
			victim_nr     = 1'b0;
			have          = 1'b0;
			far           = '0;
			// lowest matching live slot takes the hit
			for (int s = 0; s < live; s++) begin
				if (slot_valid[s] && slot_key[s] == k) begin
					slot_next[s] = nr ? '0 : nu;
					slot_nr[s]   = nr;
					r.hit        = 1'b1;
					pending.push_back(r);
					return;
				end
			end
			// lowest free live slot
			for (int s = 0; s < live; s++) begin
				if (!slot_valid[s]) begin
					store_entry(s, k, nu, nr);
					r.outcome = ocr_pkg::OUT_FILL;
					pending.push_back(r);
					return;
				end
			end
			if (nr) begin
				r.outcome = ocr_pkg::OUT_BYPASS;
				pending.push_back(r);
				return;
			end
			// never-reused entries go first, else the farthest next use
			for (int s = 0; s < live; s++) begin
				if (slot_nr[s]) begin
					victim    = s;
					victim_nr = 1'b1;
					break;
				end
				if (!have || slot_next[s] > far) begin
					far    = slot_next[s];
					victim = s;
					have   = 1'b1;
				end
			end
			if (!victim_nr && far < nu) begin
				r.outcome = ocr_pkg::OUT_BYPASS;
			end else begin
				r.outcome     = ocr_pkg::OUT_EVICT;
				r.evicted_key = slot_key[victim];
				store_entry(victim, k, nu, nr);
			end
			pending.push_back(r);
		endfunction

		// accepted result beat: compare with the oldest prediction
		function void check_result(logic h, logic [1:0] oc, logic [DATA_BITS-1:0] ek);
			cache_result_t e;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("result beat with nothing pending: hit %0b outcome %0d evicted %h",
						h, oc, ek);
				return;
			end
			e = pending.pop_front();
			if (h !== e.hit || oc !== e.outcome || ek !== e.evicted_key) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("mismatch: hit %0b/%0b outcome %0d/%0d evicted %h/%h (exp/act)",
						e.hit, h, e.outcome, oc, e.evicted_key, ek);
			end
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_write_en;
	logic [CFG_BITS-1:0]  cfg_write_data;
	logic                 access_valid;
	logic                 access_stall;
	logic [DATA_BITS-1:0] access_key;
	logic [DATA_BITS-1:0] next_use;
	logic                 no_reuse;
	logic                 result_valid;
	logic                 result_stall;
	logic                 hit;
	logic [1:0]           outcome;
	logic [DATA_BITS-1:0] evicted_key;

	cache_scoreboard sb;
	bit              burst_mode = 1'b0;
	int              hold_cycles = 0;
	int              idle_count = 0;

	optimal_replacement_cache_core #(
		.CAPACITY(CAPACITY),
		.KEY_BITS(32)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_write_data(cfg_write_data),
		.access_valid  (access_valid),
		.access_stall  (access_stall),
		.access_key    (access_key),
		.next_use      (next_use),
		.no_reuse      (no_reuse),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.hit           (hit),
		.outcome       (outcome),
		.evicted_key   (evicted_key)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog on cycles without any beat moving
	always @(posedge clk) begin
		if ((access_valid && !access_stall) || (result_valid && !result_stall)) begin
			idle_count <= 0;
		end else if (idle_count >= IDLE_LIMIT) begin
			$display("optimal_replacement_cache_core test failed");
			$finish;
		end else begin
			idle_count <= idle_count + 1;
		end
	end

	// one access beat, after a random gap unless in burst mode
	task automatic send_access(input logic [DATA_BITS-1:0] k, input logic [DATA_BITS-1:0] nu,
			input logic nr);
		int gap;
		gap = burst_mode ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			access_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		access_valid <= 1'b1;
		access_key   <= k;
		next_use     <= nu;
		no_reuse     <= nr;
		do @(posedge clk); while (access_stall);
		sb.note_access(k, nu, nr);
	endtask

	// stop offering and wait for every predicted result
	task automatic drain();
		access_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	task automatic write_active(input logic [CFG_BITS-1:0] v);
		cfg_write_en   <= 1'b1;
		cfg_write_data <= v;
		@(posedge clk);
		sb.set_active(v);
		cfg_write_en <= 1'b0;
	endtask

	// result side: random stalls, plus one long hold when asked
	initial begin : result_side
		int n;
		@(posedge arst_n);
		forever begin
			if (hold_cycles > 0) begin
				n = hold_cycles;
				hold_cycles = 0;
			end else begin
				n = burst_mode ? 0 : $urandom_range(0, 3);
			end
			if (n > 0) begin
				result_stall <= 1'b1;
				repeat (n) @(posedge clk);
				result_stall <= 1'b0;
			end
			do @(posedge clk); while (!result_valid);
			sb.check_result(hit, outcome, evicted_key);
		end
	end

	initial begin : access_side
		logic [DATA_BITS-1:0] key_pool [POOL_MAX];
		logic [DATA_BITS-1:0] k;
		logic [DATA_BITS-1:0] nu;
		logic [CFG_BITS-1:0]  cfg;
		int                   pool_n;
		int                   sent;
		int                   phase;
		int                   items;
		bit                   nr;
		sb             = new();
		arst_n         <= 1'b0;
		cfg_write_en   <= 1'b0;
		cfg_write_data <= '0;
		access_valid   <= 1'b0;
		access_key     <= '0;
		next_use       <= '0;
		no_reuse       <= 1'b0;
		result_stall   <= 1'b0;
		for (int i = 0; i < POOL_MAX; i++) key_pool[i] = $urandom;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: two entries, fills, hits, bypass, ties and never-reused victims
		write_active(5'd2);
		send_access(32'h0000_0000, 32'd10, 1'b0);
		send_access(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
		send_access(32'h0000_0000, 32'd5, 1'b0);
		send_access(32'd7, 32'd3, 1'b1);
		send_access(32'd8, 32'hFFFF_FFFF, 1'b0);
		send_access(32'h0000_0000, 32'd0, 1'b1);
		send_access(32'd9, 32'd1, 1'b0);
		send_access(32'd10, 32'd2, 1'b0);
		send_access(32'd11, 32'd3, 1'b0);
		send_access(32'd12, 32'd2, 1'b0);
		drain();
		// zero count acts as one; leaves a duplicate key above it
		write_active(5'd0);
		send_access(32'd12, 32'd0, 1'b0);
		send_access(32'd13, 32'hFFFF_FFFF, 1'b1);
		drain();
		write_active(5'd2);
		send_access(32'd12, 32'd7, 1'b0);
		send_access(32'd12, 32'hFFFF_FFFF, 1'b0);
		drain();
		// above capacity acts as capacity; equal next uses tie to the lowest slot
		write_active(5'd31);
		for (int i = 0; i < 15; i++) send_access(32'h100 + i, 32'd50, 1'b0);
		send_access(32'h200, 32'd50, 1'b0);
		drain();

		// random phases over the count, the key pool and the idling pattern
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			case (phase)
				0: cfg = 5'd1;
				1: cfg = 5'd16;
				default: begin
					case ($urandom_range(0, 7))
						0: cfg = 5'd0;
						1: cfg = 5'd1;
						2: cfg = CFG_BITS'(CAPACITY);
						3: cfg = CFG_BITS'($urandom_range(17, 31));
						default: cfg = CFG_BITS'($urandom_range(1, 16));
					endcase
				end
			endcase
			write_active(cfg);
			burst_mode = (phase == 3) || ($urandom_range(0, 3) == 0);
			if (phase == 3) hold_cycles = LONG_HOLD;
			// keep the pool now and then so old keys meet a new count
			if ($urandom_range(0, 1) == 0) begin
				for (int i = 0; i < POOL_MAX; i++) begin
					case ($urandom_range(0, 15))
						0: key_pool[i] = '0;
						1: key_pool[i] = '1;
						default: key_pool[i] = $urandom;
					endcase
				end
			end
			pool_n = $urandom_range(2, POOL_MAX);
			items  = $urandom_range(60, 160);
			if (items > RANDOM_ITEMS - sent) items = RANDOM_ITEMS - sent;
			repeat (items) begin
				k = ($urandom_range(0, 15) == 0) ? $urandom : key_pool[$urandom_range(0, pool_n - 1)];
				case ($urandom_range(0, 9))
					0: nu = '0;
					1: nu = '1;
					2: nu = $urandom;
					default: nu = $urandom_range(0, 63);
				endcase
				nr = ($urandom_range(0, 7) == 0);
				send_access(k, nu, nr);
				sent++;
				if ($urandom_range(0, 49) == 0) drain();
			end
			drain();
			phase++;
		end

		burst_mode = 1'b0;
		repeat (2 * LATENCY) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending.size() == 0) begin
			$display("optimal_replacement_cache_core test passed");
		end else begin
			$display("optimal_replacement_cache_core test failed");
		end
		$finish;
	end

endmodule

@@ optimal_replacement_cache_core.f @@
design/ocr_pkg.sv
design/ocr_cell.sv
design/optimal_replacement_cache_core.sv
tb/sv/tb.sv
